// ----- sv/i2cm_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
// No dependencies; imported by i2cm_core and i2c_master_byte_engine.
package i2cm_pkg;

    // Command codes, also the opcode values on the input word
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_STOP  = 3'd4
    } cmd_t;

    // Phase steps; 0..3 are the start/stop condition steps
    localparam logic [2:0] PH_BIT_LOW  = 3'd4;
    localparam logic [2:0] PH_BIT_HIGH = 3'd5;
    localparam logic [2:0] PH_READ_END = 3'd6;

    localparam logic [3:0] BYTE_BITS    = 4'd8;
    localparam logic [6:0] ADDR_RESET   = 7'd79;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // One result word
    typedef struct packed {
        logic [7:0] read_data;
        logic       nack_seen;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_out;
    } result_t;

endpackage

// ----- sv/i2cm_core.sv -----
// Bus phase engine: command/phase state registers and the per-word step logic.
// Depends on i2cm_pkg.
module i2cm_core import i2cm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [2:0] opcode,
    input  logic [7:0] tx_byte,
    input  logic       read_not_write,
    input  logic       send_ack,
    input  logic       sda_in,
    input  logic       cfg_we,
    input  logic [6:0] cfg_addr,
    output result_t    result
);

    cmd_t       cmd_reg, cmd_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] bits_reg, bits_next;
    logic [7:0] shift_reg, shift_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       nack_reg, nack_next;
    logic       ack_reg, ack_next;
    logic [7:0] hold_reg, hold_next;
    logic [6:0] addr_reg;
    logic       done;
    logic       opc_valid;

    assign opc_valid = (opcode == CMD_START) || (opcode == CMD_WRITE) ||
                       (opcode == CMD_READ)  || (opcode == CMD_STOP);

    // Command launch, then one bus phase
    always_comb begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        nack_next  = nack_reg;
        ack_next   = ack_reg;
        hold_next  = hold_reg;
        done       = 1'b0;
        if (step_en) begin
            if (cmd_reg == CMD_IDLE && opc_valid) begin
                cmd_next   = cmd_t'(opcode);
                phase_next = 3'd0;
                case (cmd_t'(opcode))
                    CMD_START: bits_next = {3'b000, read_not_write}; // direction bit parked
                    CMD_WRITE: begin
                        shift_next = tx_byte;
                        bits_next  = BYTE_BITS;
                        phase_next = PH_BIT_LOW;
                    end
                    CMD_READ: begin
                        shift_next = 8'h00;
                        bits_next  = BYTE_BITS;
                        ack_next   = send_ack;
                        phase_next = PH_BIT_LOW;
                    end
                    default: ;
                endcase
            end
            if (cmd_next != CMD_IDLE) begin
                if (phase_next < PH_BIT_LOW &&
                    (cmd_next == CMD_START || cmd_next == CMD_STOP)) begin
                    // start / stop condition steps
                    unique case (phase_next[1:0])
                        2'd0: begin
                            scl_next   = 1'b0;
                            phase_next = phase_next + 3'd1;
                        end
                        2'd1: begin
                            sda_next   = (cmd_next == CMD_START);
                            phase_next = phase_next + 3'd1;
                        end
                        2'd2: begin
                            scl_next   = 1'b1;
                            phase_next = phase_next + 3'd1;
                        end
                        default: begin
                            if (cmd_next == CMD_STOP) begin
                                sda_next   = 1'b1;
                                cmd_next   = CMD_IDLE;
                                phase_next = 3'd0;
                                done       = 1'b1;
                            end else begin
                                sda_next   = 1'b0;
                                shift_next = {addr_reg, bits_next[0]};
                                bits_next  = BYTE_BITS;
                                phase_next = PH_BIT_LOW;
                            end
                        end
                    endcase
                end else if (phase_next == PH_BIT_LOW) begin
                    // low phase: set up SDA
                    scl_next = 1'b0;
                    if (bits_next != 4'd0)
                        sda_next = (cmd_next == CMD_READ) ? 1'b1 : shift_next[7];
                    else
                        sda_next = (cmd_next == CMD_READ) ? ~ack_next : 1'b1;
                    phase_next = PH_BIT_HIGH;
                end else if (phase_next == PH_BIT_HIGH) begin
                    // high phase: sample SDA
                    scl_next = 1'b1;
                    if (bits_next != 4'd0) begin
                        shift_next = {shift_next[6:0],
                                      (cmd_next == CMD_READ) ? sda_in : 1'b0};
                        bits_next  = bits_next - 4'd1;
                        phase_next = PH_BIT_LOW;
                    end else if (cmd_next == CMD_READ) begin
                        phase_next = PH_READ_END;
                    end else begin
                        nack_next  = sda_in;
                        cmd_next   = CMD_IDLE;
                        phase_next = 3'd0;
                        done       = 1'b1;
                    end
                end else if (phase_next == PH_READ_END && cmd_next == CMD_READ) begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b1;
                    hold_next  = shift_next;
                    cmd_next   = CMD_IDLE;
                    phase_next = 3'd0;
                    done       = 1'b1;
                end else begin
                    cmd_next   = CMD_IDLE;
                    phase_next = 3'd0;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= 3'd0;
            bits_reg  <= 4'd0;
            shift_reg <= 8'h00;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            nack_reg  <= 1'b0;
            ack_reg   <= 1'b0;
            hold_reg  <= 8'h00;
            addr_reg  <= ADDR_RESET;
        end else begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            nack_reg  <= nack_next;
            ack_reg   <= ack_next;
            hold_reg  <= hold_next;
            if (cfg_we)
                addr_reg <= cfg_addr;
        end
    end

    // Result seen after this word's step
    always_comb begin
        result.scl_out     = scl_next;
        result.sda_release = sda_next;
        result.busy_res    = (cmd_next != CMD_IDLE);
        result.done_res    = done;
        result.nack_seen   = nack_next;
        result.read_data   = hold_next;
    end

endmodule

// ----- sv/i2c_master_byte_engine.sv -----
// Top level of the I2C master byte engine: stream ports and result buffer.
// Depends on i2cm_pkg and i2cm_core.
// Each input word advances the I2C bus by one phase and yields exactly one
// result word. A word is taken every clock unless the output buffer is full: the
// phase step is a single level of logic from the state registers, and results
// go through a two-entry output buffer, so input keeps flowing for one word
// while a result waits on m_tready. Each result is registered in the buffer.
// The slave address register may be written at any time the engine is idle.
module i2c_master_byte_engine import i2cm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // opcode[2:0], tx_byte[10:3], read_not_write[11], send_ack[12],
    // sda_in[13], zero[15:14]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // scl_out[0], sda_release[1], busy_res[2], done_res[3], nack_seen[4],
    // read_data[12:5], zero[15:13]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [6:0]            cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    result_t res;
    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    head_vld_reg, head_vld_next;
    logic    skid_vld_reg, skid_vld_next;
    logic    push, pop;

    assign s_tready  = ~skid_vld_reg;
    assign cfg_ready = 1'b1;
    assign push      = s_tvalid & s_tready;
    assign pop       = head_vld_reg & m_tready;

    i2cm_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (push),
        .opcode         (s_tdata[2:0]),
        .tx_byte        (s_tdata[10:3]),
        .read_not_write (s_tdata[11]),
        .send_ack       (s_tdata[12]),
        .sda_in         (s_tdata[13]),
        .cfg_we         (cfg_valid),
        .cfg_addr       (cfg_data),
        .result         (res)
    );

    // Two-entry result buffer
    always_comb begin
        head_next     = head_reg;
        skid_next     = skid_reg;
        head_vld_next = head_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (pop) begin
            if (skid_vld_reg) begin
                head_next     = skid_reg;
                skid_vld_next = 1'b0;
            end else begin
                head_next     = res;
                head_vld_next = push;
            end
        end else if (push) begin
            if (!head_vld_reg) begin
                head_next     = res;
                head_vld_next = 1'b1;
            end else begin
                skid_next     = res;
                skid_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            head_vld_reg <= head_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = head_vld_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, head_reg};

endmodule
